// File: rtl/core/smp_pkg.sv
`default_nettype none

package smp_pkg;

    localparam int CountWidth = 16;
    localparam int CfgIndexWidth = 2;

    localparam logic [CountWidth-1:0] CountMax = '1;

    localparam logic [CfgIndexWidth-1:0] CFG_TICKS_PER_MINUTE = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_PULSE_TICKS      = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_GAP_TICKS        = 2'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE_TICKS   = 2'd3;

    localparam logic [CountWidth-1:0] TicksPerMinuteReset = 16'd60000;
    localparam logic [CountWidth-1:0] PulseTicksReset     = 16'd200;
    localparam logic [CountWidth-1:0] GapTicksReset       = 16'd1000;
    localparam logic [CountWidth-1:0] DebounceTicksReset  = 16'd100;
    localparam logic [CountWidth-1:0] PulseTicksMin       = 16'd2;

    typedef logic [CountWidth-1:0] count_t;

    typedef struct packed {
        logic clean;
        logic released;
    } debounce_status_t;

endpackage

`default_nettype wire

// File: rtl/core/smp_if.sv
`default_nettype none

interface smp_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

interface smp_out_if
    import smp_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   solenoid_drive;
    count_t owed_minutes;
    logic   clean_button;

    modport source (output valid, output solenoid_drive, output owed_minutes,
                    output clean_button, input ready);
    modport sink (input valid, input solenoid_drive, input owed_minutes,
                  input clean_button, output ready);
endinterface

`default_nettype wire

// File: rtl/core/slave_clock_minute_pulser_core.sv
`default_nettype none
// A result item appears in the output register in the cycle after its tick item is taken.
// Throughput: one item per cycle unless stalled; state counters update in one pass per item.
// The input stays ready while the output register is empty or is being emptied.
// Reset clears the state counters and flags and loads the configuration registers with defaults.

module slave_clock_minute_pulser_core
    import smp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    smp_in_if.sink                        in,
    smp_out_if.source                     out,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire count_t                   cfg_data
);

    count_t ticks_per_minute_reg;
    count_t pulse_ticks_reg;
    count_t gap_ticks_reg;
    count_t debounce_ticks_reg;

    count_t tick_count_reg;
    count_t tick_count_next;
    count_t backlog_reg;
    count_t backlog_next;
    count_t pulse_left_reg;
    count_t pulse_left_next;
    count_t gap_left_reg;
    count_t gap_left_next;
    logic   end_pending_reg;
    logic   end_pending_next;
    logic   solenoid_reg;
    logic   solenoid_next;

    logic   out_valid_reg;
    logic   out_solenoid_reg;
    count_t out_owed_reg;
    logic   out_clean_reg;

    logic   accept;
    count_t tick_inc;
    count_t backlog_a;
    count_t backlog_b;
    count_t pulse_a;
    count_t pulse_load;
    count_t gap_a;
    logic   solenoid_a;
    debounce_status_t deb;

    assign in.ready = !out_valid_reg || out.ready;
    assign accept = in.valid && in.ready;

    smp_debounce u_debounce
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept),
        .raw            (in.button_level),
        .debounce_ticks (debounce_ticks_reg),
        .status         (deb)
    );

    always_comb
    begin
        tick_inc = tick_count_reg + count_t'(1);
        tick_count_next = tick_inc;
        backlog_a = backlog_reg;
        if (tick_inc == ticks_per_minute_reg)
        begin
            tick_count_next = '0;
            if (backlog_reg != CountMax)
            begin
                backlog_a = backlog_reg + count_t'(1);
            end
        end

        pulse_load = (pulse_ticks_reg < PulseTicksMin) ? PulseTicksMin : pulse_ticks_reg;
        backlog_b = backlog_a;
        pulse_a = pulse_left_reg;
        gap_a = gap_left_reg;
        solenoid_a = solenoid_reg;
        if (gap_left_reg != '0)
        begin
            gap_a = gap_left_reg - count_t'(1);
        end
        else if (backlog_a != '0 && pulse_left_reg == '0 && !end_pending_reg)
        begin
            backlog_b = backlog_a - count_t'(1);
            pulse_a = pulse_load;
            solenoid_a = 1'b1;
        end

        pulse_left_next = pulse_a;
        gap_left_next = gap_a;
        solenoid_next = solenoid_a;
        end_pending_next = end_pending_reg;
        if (pulse_a != '0)
        begin
            pulse_left_next = pulse_a - count_t'(1);
            if (pulse_left_next == count_t'(1))
            begin
                end_pending_next = 1'b1;
            end
        end
        else if (end_pending_reg)
        begin
            solenoid_next = 1'b0;
            gap_left_next = gap_ticks_reg;
            end_pending_next = 1'b0;
        end

        backlog_next = backlog_b;
        if (deb.released)
        begin
            tick_count_next = '0;
            if (backlog_b != CountMax)
            begin
                backlog_next = backlog_b + count_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_minute_reg <= TicksPerMinuteReset;
            pulse_ticks_reg <= PulseTicksReset;
            gap_ticks_reg <= GapTicksReset;
            debounce_ticks_reg <= DebounceTicksReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TICKS_PER_MINUTE: ticks_per_minute_reg <= cfg_data;
                CFG_PULSE_TICKS:      pulse_ticks_reg <= cfg_data;
                CFG_GAP_TICKS:        gap_ticks_reg <= cfg_data;
                CFG_DEBOUNCE_TICKS:   debounce_ticks_reg <= cfg_data;
                default:              ticks_per_minute_reg <= ticks_per_minute_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            backlog_reg <= '0;
            pulse_left_reg <= '0;
            gap_left_reg <= '0;
            end_pending_reg <= 1'b0;
            solenoid_reg <= 1'b0;
        end
        else if (accept)
        begin
            tick_count_reg <= tick_count_next;
            backlog_reg <= backlog_next;
            pulse_left_reg <= pulse_left_next;
            gap_left_reg <= gap_left_next;
            end_pending_reg <= end_pending_next;
            solenoid_reg <= solenoid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_solenoid_reg <= solenoid_next;
            out_owed_reg <= backlog_next;
            out_clean_reg <= deb.clean;
        end
    end

    assign out.valid = out_valid_reg;
    assign out.solenoid_drive = out_solenoid_reg;
    assign out.owed_minutes = out_owed_reg;
    assign out.clean_button = out_clean_reg;

endmodule

`default_nettype wire

// File: rtl/core/smp_debounce.sv
`default_nettype none

module smp_debounce
    import smp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             raw,
    input  wire count_t           debounce_ticks,
    output debounce_status_t      status
);

    logic   last_raw_reg;
    logic   last_raw_next;
    count_t stable_count_reg;
    count_t stable_count_next;
    logic   button_now_reg;
    logic   button_now_next;
    logic   level_accepted;

    always_comb
    begin
        if (raw == last_raw_reg)
        begin
            if (stable_count_reg < debounce_ticks)
            begin
                stable_count_next = stable_count_reg + count_t'(1);
            end
            else
            begin
                stable_count_next = stable_count_reg;
            end
        end
        else
        begin
            stable_count_next = '0;
        end
        last_raw_next = raw;
        level_accepted = (stable_count_next >= debounce_ticks);
        button_now_next = level_accepted ? raw : button_now_reg;
        status.released = level_accepted && button_now_reg && !raw;
        status.clean = button_now_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= 1'b0;
            stable_count_reg <= '0;
            button_now_reg <= 1'b0;
        end
        else if (step)
        begin
            last_raw_reg <= last_raw_next;
            stable_count_reg <= stable_count_next;
            button_now_reg <= button_now_next;
        end
    end

endmodule

`default_nettype wire
